// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the nmea sentence parser rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with an explicit clock and active-low reset
`define NSP_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion on the block clock and reset
`define NSP_ASSERT(label, prop, msg) `NSP_ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)

`endif

// ===== hw/rtl/nsp_pkg.sv =====
// package for the nmea sentence parser: character codes, hex decode, result type
// no dependencies
`timescale 1ns / 1ps

package nsp_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF     = 8'h66;
    localparam logic [7:0] HEX_TEN   = 8'd10;

    // first-field length where the address is complete, and talker length
    localparam logic [2:0] ADDR_LEN   = 3'd5;
    localparam logic [2:0] TALKER_LEN = 3'd2;

    // checksum position after the star
    localparam logic [1:0] STAR_NONE = 2'd0;
    localparam logic [1:0] STAR_HIGH = 2'd1;
    localparam logic [1:0] STAR_LOW  = 2'd2;
    localparam logic [1:0] STAR_DONE = 2'd3;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    typedef struct packed {
        logic [7:0]  char_out;
        logic [4:0]  field_index;
        logic        is_content;
        logic        line_done;
        logic        start_ok;
        logic        checksum_ok;
        logic [5:0]  field_total;
        logic        address_found;
        logic [15:0] talker_code;
        logic [23:0] sentence_code;
    } t_result;

    function automatic t_hex hex_decode(input logic [7:0] ch);
        t_hex h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (ch >= CH_0 && ch <= CH_9) begin
            h.val = 4'(ch - CH_0);
        end else if (ch >= CH_UA && ch <= CH_UF) begin
            h.val = 4'(ch - CH_UA + HEX_TEN);
        end else if (ch >= CH_LA && ch <= CH_LF) begin
            h.val = 4'(ch - CH_LA + HEX_TEN);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

// ===== hw/rtl/nsp_line_tracker.sv =====
// per-line state of the nmea parser and the result logic for one character
// depends on nsp_pkg
`timescale 1ns / 1ps

module nsp_line_tracker #(
    parameter int FIELD_LIMIT = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  logic [7:0]       i_char,
    input  logic             i_line_end,
    output nsp_pkg::t_result o_result
);

    localparam int FW = $clog2(FIELD_LIMIT);
    localparam int CW = FW + 1;
    localparam logic [CW-1:0] LIMIT_C = CW'(FIELD_LIMIT);

    logic          r_start, n_start, u_start;
    logic          r_acc, n_acc, u_acc;
    logic [1:0]    r_star, n_star, u_star;
    logic [7:0]    r_xor, n_xor, u_xor;
    logic [3:0]    r_high, n_high, u_high;
    logic          r_hexg, n_hexg, u_hexg;
    logic          r_cs, n_cs, u_cs;
    logic [FW-1:0] r_field, n_field, u_field;
    logic [2:0]    r_len, n_len, u_len;
    logic [15:0]   r_two, n_two, u_two;
    logic [23:0]   r_three, n_three, u_three;

    logic [FW-1:0] fidx;
    logic          content;
    nsp_pkg::t_hex hex;
    logic [5:0]    fidx6;

    always_comb begin
        hex     = nsp_pkg::hex_decode(i_char);
        u_start = r_start;
        u_acc   = r_acc;
        u_star  = r_star;
        u_xor   = r_xor;
        u_high  = r_high;
        u_hexg  = r_hexg;
        u_cs    = r_cs;
        u_field = r_field;
        u_len   = r_len;
        u_two   = r_two;
        u_three = r_three;
        fidx    = '0;
        content = 1'b0;

        if (r_start) begin
            u_start = 1'b0;
            u_acc   = (i_char == nsp_pkg::CH_DOLLAR) || (i_char == nsp_pkg::CH_BANG);
        end else if (!r_acc) begin
            // rejected line, pass through
        end else if (r_star == nsp_pkg::STAR_NONE) begin
            fidx = r_field;
            if (i_char == nsp_pkg::CH_STAR) begin
                u_star = nsp_pkg::STAR_HIGH;
            end else begin
                u_xor = r_xor ^ i_char;
                if (i_char == nsp_pkg::CH_COMMA && (CW'(r_field) + CW'(1)) < LIMIT_C) begin
                    u_field = r_field + FW'(1);
                end else begin
                    content = 1'b1;
                    if (r_field == '0) begin
                        if (r_len < nsp_pkg::TALKER_LEN) begin
                            u_two = {r_two[7:0], i_char};
                        end
                        u_three = {r_three[15:0], i_char};
                        if (r_len < nsp_pkg::ADDR_LEN) begin
                            u_len = r_len + 3'd1;
                        end
                    end
                end
            end
        end else begin
            fidx = r_field;
            if (r_star != nsp_pkg::STAR_DONE) begin
                u_hexg = r_hexg && hex.ok;
                if (r_star == nsp_pkg::STAR_HIGH) begin
                    u_high = hex.val;
                    u_star = nsp_pkg::STAR_LOW;
                end else begin
                    u_cs   = r_hexg && hex.ok && ({r_high, hex.val} == r_xor);
                    u_star = nsp_pkg::STAR_DONE;
                end
            end
        end

        // a finished line returns everything to the idle line state
        n_start = i_line_end ? 1'b1 : u_start;
        n_acc   = i_line_end ? 1'b0 : u_acc;
        n_star  = i_line_end ? nsp_pkg::STAR_NONE : u_star;
        n_xor   = i_line_end ? 8'd0 : u_xor;
        n_high  = i_line_end ? 4'd0 : u_high;
        n_hexg  = i_line_end ? 1'b1 : u_hexg;
        n_cs    = i_line_end ? 1'b0 : u_cs;
        n_field = i_line_end ? '0 : u_field;
        n_len   = i_line_end ? 3'd0 : u_len;
        n_two   = i_line_end ? 16'd0 : u_two;
        n_three = i_line_end ? 24'd0 : u_three;

        fidx6                  = 6'(fidx);
        o_result               = '0;
        o_result.char_out      = i_char;
        o_result.field_index   = fidx6[4:0];
        o_result.is_content    = content;
        o_result.line_done     = i_line_end;
        if (i_line_end && u_acc) begin
            o_result.start_ok    = 1'b1;
            o_result.checksum_ok = u_cs;
            o_result.field_total = 6'(u_field) + 6'd1;
            if (u_len >= nsp_pkg::ADDR_LEN) begin
                o_result.address_found = 1'b1;
                o_result.talker_code   = u_two;
                o_result.sentence_code = u_three;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= 1'b1;
            r_acc   <= 1'b0;
            r_star  <= nsp_pkg::STAR_NONE;
            r_xor   <= 8'd0;
            r_high  <= 4'd0;
            r_hexg  <= 1'b1;
            r_cs    <= 1'b0;
            r_field <= '0;
            r_len   <= 3'd0;
            r_two   <= 16'd0;
            r_three <= 24'd0;
        end else if (i_advance) begin
            r_start <= n_start;
            r_acc   <= n_acc;
            r_star  <= n_star;
            r_xor   <= n_xor;
            r_high  <= n_high;
            r_hexg  <= n_hexg;
            r_cs    <= n_cs;
            r_field <= n_field;
            r_len   <= n_len;
            r_two   <= n_two;
            r_three <= n_three;
        end
    end

endmodule

// ===== hw/rtl/nsp_out_reg.sv =====
// result register of the nmea parser with valid/stall handshake
// depends on nsp_pkg
`timescale 1ns / 1ps

module nsp_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  nsp_pkg::t_result i_result,
    input  logic             i_out_stall,
    output logic             o_valid,
    output nsp_pkg::t_result o_result,
    output logic             o_in_stall
);

    logic             r_valid;
    nsp_pkg::t_result r_result;

    // full and not drained this cycle
    assign o_in_stall = r_valid && i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== hw/rtl/nmea_sentence_parser_core.sv =====
// top level of the nmea 0183 sentence parser
// depends on nsp_pkg, nsp_line_tracker, nsp_out_reg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

// The parser takes one character per transaction and returns exactly one result
// transaction per character, in the cycle after it is taken. Unless stalled, it
// sustains one character per clock: the per-character work is a byte compare, an
// xor and a hex decode between the line-state registers and the result register,
// and the result register is the only buffer. o_in_stall is high only while that
// register is full and the downstream side stalls it, so it follows i_out_stall in
// the same cycle. A line must start with '$' or '!'; the result for the character
// flagged by i_line_end carries the line summary, and the line state then returns
// to reset, so the next character opens a new line. Fields beyond FIELD_LIMIT are
// merged into the last field.

module nmea_sentence_parser_core #(
    parameter int FIELD_LIMIT = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // character input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_char_in,
    input  logic        i_line_end,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_char_out,
    output logic [4:0]  o_field_index,
    output logic        o_is_content,
    output logic        o_line_done,
    output logic        o_start_ok,
    output logic        o_checksum_ok,
    output logic [5:0]  o_field_total,
    output logic        o_address_found,
    output logic [15:0] o_talker_code,
    output logic [23:0] o_sentence_code
);

    logic             accept;
    nsp_pkg::t_result next_result;
    nsp_pkg::t_result out_result;

    // a character transaction completes when valid and not stalled
    assign accept = i_in_valid && !o_in_stall;

    // line state and per-character decode
    nsp_line_tracker #(
        .FIELD_LIMIT (FIELD_LIMIT)
    ) u_tracker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (accept),
        .i_char     (i_char_in),
        .i_line_end (i_line_end),
        .o_result   (next_result)
    );

    // result register, parts the two handshakes
    nsp_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_result    (next_result),
        .i_out_stall (i_out_stall),
        .o_valid     (o_out_valid),
        .o_result    (out_result),
        .o_in_stall  (o_in_stall)
    );

    assign o_char_out      = out_result.char_out;
    assign o_field_index   = out_result.field_index;
    assign o_is_content    = out_result.is_content;
    assign o_line_done     = out_result.line_done;
    assign o_start_ok      = out_result.start_ok;
    assign o_checksum_ok   = out_result.checksum_ok;
    assign o_field_total   = out_result.field_total;
    assign o_address_found = out_result.address_found;
    assign o_talker_code   = out_result.talker_code;
    assign o_sentence_code = out_result.sentence_code;

    // every accepted character shows up as a result on the next clock
    `NSP_ASSERT(a_result_follows, accept |=> o_out_valid, "accepted character gave no result")

    // summary fields stay clear except on the final character of a line
    `NSP_ASSERT(a_summary_only_at_end,
        (o_out_valid && !o_line_done) |-> (!o_start_ok && !o_checksum_ok &&
        o_field_total == 6'd0 && !o_address_found), "summary set before line end")

    // a rejected line reports nothing
    `NSP_ASSERT(a_rejected_line,
        (o_out_valid && o_line_done && !o_start_ok) |-> (!o_checksum_ok &&
        o_field_total == 6'd0 && !o_address_found), "rejected line carries a summary")

    // address codes only with a complete address field
    `NSP_ASSERT(a_address_codes,
        (o_out_valid && !o_address_found) |-> (o_talker_code == 16'd0 &&
        o_sentence_code == 24'd0), "address codes without address")

endmodule
